/* hw/rtl/mi3_pkg.sv */
// Shared types, widths and pipeline stage numbers for the 3x3 matrix inverse unit
`timescale 1ns / 1ps

package mi3_pkg;

   // entry format
   localparam int ENTRY_W = 32;
   localparam int FRAC_W  = 16;

   // internal widths
   localparam int PROD_W  = 2 * ENTRY_W;              // exact product of two entries
   localparam int COF_W   = PROD_W - FRAC_W + 1;      // cofactor, full precision
   localparam int DLO_W   = 24;                       // low slice of a cofactor
   localparam int DHI_W   = COF_W - DLO_W;            // high slice of a cofactor
   localparam int DPP_W   = ENTRY_W + DHI_W;          // partial product width
   localparam int DFULL_W = ENTRY_W + COF_W;          // exact entry * cofactor
   localparam int DTERM_W = DFULL_W - FRAC_W;         // floored determinant term
   localparam int DET_W   = DTERM_W + 2;              // sum of three terms
   localparam int NUM_W   = COF_W + FRAC_W;           // cofactor << FRAC_W
   localparam int QUO_W   = ENTRY_W;                  // quotient bits resolved
   localparam int REM_W   = DET_W + QUO_W;            // partial remainder

   // pipeline stages
   localparam int ST_PROD   = 0;
   localparam int ST_COF    = 1;
   localparam int ST_DPP    = 2;
   localparam int ST_DTERM  = 3;
   localparam int ST_DET    = 4;
   localparam int ST_ABS    = 5;
   localparam int ST_OVF    = 6;
   localparam int DIV_STEPS = QUO_W;
   localparam int ST_OUT    = ST_OVF + DIV_STEPS + 1;
   localparam int NST       = ST_OUT + 1;

   localparam int NLANE = 9;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] a_r0c0;
      logic signed [ENTRY_W-1:0] a_r0c1;
      logic signed [ENTRY_W-1:0] a_r0c2;
      logic signed [ENTRY_W-1:0] a_r1c0;
      logic signed [ENTRY_W-1:0] a_r1c1;
      logic signed [ENTRY_W-1:0] a_r1c2;
      logic signed [ENTRY_W-1:0] a_r2c0;
      logic signed [ENTRY_W-1:0] a_r2c1;
      logic signed [ENTRY_W-1:0] a_r2c2;
   } mi3_req_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] inv_r0c0;
      logic signed [ENTRY_W-1:0] inv_r0c1;
      logic signed [ENTRY_W-1:0] inv_r0c2;
      logic signed [ENTRY_W-1:0] inv_r1c0;
      logic signed [ENTRY_W-1:0] inv_r1c1;
      logic signed [ENTRY_W-1:0] inv_r1c2;
      logic signed [ENTRY_W-1:0] inv_r2c0;
      logic signed [ENTRY_W-1:0] inv_r2c1;
      logic signed [ENTRY_W-1:0] inv_r2c2;
      logic                      singular;
      logic                      saturated;
   } mi3_rsp_type;

endpackage

/* hw/rtl/mi3_cof_lane.sv */
// One cofactor lane: two floored 2x2 products and their difference
`timescale 1ns / 1ps

module mi3_cof_lane
   import mi3_pkg::*;
(
   input  logic                      clock,
   input  logic                      adv,
   input  logic signed [ENTRY_W-1:0] a,
   input  logic signed [ENTRY_W-1:0] b,
   input  logic signed [ENTRY_W-1:0] c,
   input  logic signed [ENTRY_W-1:0] d,
   output logic signed [COF_W-1:0]   cof
);

   logic signed [PROD_W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [COF_W-1:0]  cof_ff, cof_in;

   // exact products
   always_comb begin
      p1_in = a * b;
      p2_in = c * d;
   end

   // floor each product to the fraction width, then subtract
   always_comb begin
      cof_in = {p1_ff[PROD_W-1], p1_ff[PROD_W-1:FRAC_W]}
             - {p2_ff[PROD_W-1], p2_ff[PROD_W-1:FRAC_W]};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         cof_ff <= cof_in;
      end
   end

   assign cof = cof_ff;

endmodule

/* hw/rtl/mi3_det.sv */
// Determinant: first row dotted with its cofactors, products split over two stages
`timescale 1ns / 1ps

module mi3_det
   import mi3_pkg::*;
(
   input  logic                      clock,
   input  logic                      adv,
   input  logic signed [ENTRY_W-1:0] row0 [3],
   input  logic signed [COF_W-1:0]   cof0 [3],
   output logic signed [DET_W-1:0]   det
);

   logic signed [ENTRY_W-1:0] m0_ff [3];
   logic signed [ENTRY_W-1:0] m1_ff [3];
   logic signed [DPP_W-1:0]   lo_ff [3], lo_in [3];
   logic signed [DPP_W-1:0]   hi_ff [3], hi_in [3];
   logic signed [DTERM_W-1:0] term_ff [3], term_in [3];
   logic signed [DFULL_W-1:0] full [3];
   logic signed [DET_W-1:0]   det_ff, det_in;

   // partial products on the low and high slices of each cofactor
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = m1_ff[i] * $signed({1'b0, cof0[i][DLO_W-1:0]});
         hi_in[i] = m1_ff[i] * $signed(cof0[i][COF_W-1:DLO_W]);
      end
   end

   // recombine the slices and floor
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         full[i]    = {hi_ff[i], {DLO_W{1'b0}}}
                    + {{(DFULL_W-DPP_W){lo_ff[i][DPP_W-1]}}, lo_ff[i]};
         term_in[i] = full[i][DFULL_W-1:FRAC_W];
      end
   end

   // sum the three terms
   always_comb begin
      det_in = {{2{term_ff[0][DTERM_W-1]}}, term_ff[0]}
             + {{2{term_ff[1][DTERM_W-1]}}, term_ff[1]}
             + {{2{term_ff[2][DTERM_W-1]}}, term_ff[2]};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_ff   <= row0;
         m1_ff   <= m0_ff;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         term_ff <= term_in;
         det_ff  <= det_in;
      end
   end

   assign det = det_ff;

endmodule

/* hw/rtl/mi3_div_lane.sv */
// One divider lane: (cofactor << FRAC_W) / det, one quotient bit per stage, then saturate
`timescale 1ns / 1ps

module mi3_div_lane
   import mi3_pkg::*;
(
   input  logic                      clock,
   input  logic                      adv,
   input  logic signed [COF_W-1:0]   cof,
   input  logic signed [DET_W-1:0]   det,
   output logic signed [ENTRY_W-1:0] res,
   output logic                      sat
);

   logic [NUM_W-1:0]  nmag_ff, nmag_in;
   logic [DET_W-1:0]  dmag_ff, dmag_in;
   logic              flip5_ff;
   logic [NUM_W-1:0]  num_sh;

   logic [REM_W-1:0]  rem_ff  [DIV_STEPS];
   logic [DET_W-1:0]  d_ff    [DIV_STEPS];
   logic [QUO_W-1:0]  q_ff    [DIV_STEPS+1];
   logic              flip_ff [DIV_STEPS+1];
   logic              ovf_ff  [DIV_STEPS+1];
   logic              ovf_in;
   logic [QUO_W-1:0]  q;

   // magnitudes and the sign of the quotient
   always_comb begin
      num_sh  = {cof, {FRAC_W{1'b0}}};
      nmag_in = cof[COF_W-1] ? (~num_sh + 1'b1) : num_sh;
      dmag_in = det[DET_W-1] ? (~det + 1'b1) : det;
   end

   // quotient does not fit QUO_W bits
   assign ovf_in = {{(REM_W-NUM_W){1'b0}}, nmag_ff} >= {dmag_ff, {QUO_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         nmag_ff     <= nmag_in;
         dmag_ff     <= dmag_in;
         flip5_ff    <= cof[COF_W-1] ^ det[DET_W-1];
         rem_ff[0]   <= {{(REM_W-NUM_W){1'b0}}, nmag_ff};
         d_ff[0]     <= dmag_ff;
         q_ff[0]     <= '0;
         flip_ff[0]  <= flip5_ff;
         ovf_ff[0]   <= ovf_in;
      end
   end

   // restoring division, most significant quotient bit first
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      localparam int K = DIV_STEPS - 1 - j;
      logic [REM_W-1:0] dk;
      logic [REM_W:0]   trial;
      logic             qbit;

      always_comb begin
         dk    = {{QUO_W{1'b0}}, d_ff[j]} << K;
         trial = {1'b0, rem_ff[j]} - {1'b0, dk};
         qbit  = ~trial[REM_W];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[j+1]    <= {q_ff[j][QUO_W-2:0], qbit};
            flip_ff[j+1] <= flip_ff[j];
            ovf_ff[j+1]  <= ovf_ff[j];
         end
      end

      if (j < DIV_STEPS - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j+1] <= qbit ? trial[REM_W-1:0] : rem_ff[j];
               d_ff[j+1]   <= d_ff[j];
            end
         end
      end
   end

   // apply sign and clip to the entry range
   assign q = q_ff[DIV_STEPS];

   always_comb begin
      if (flip_ff[DIV_STEPS]) begin
         sat = ovf_ff[DIV_STEPS] || (q[QUO_W-1] && (q[QUO_W-2:0] != '0));
         res = sat ? $signed({1'b1, {(ENTRY_W-1){1'b0}}}) : $signed(~q + 1'b1);
      end else begin
         sat = ovf_ff[DIV_STEPS] || q[QUO_W-1];
         res = sat ? $signed({1'b0, {(ENTRY_W-1){1'b1}}}) : $signed(q);
      end
   end

endmodule

/* hw/rtl/matrix3x3_inverse_unit.sv */
// Top level of the 3x3 matrix inverse unit: lanes, pipeline control and output skid
//
// Takes a 3x3 matrix of signed Q16.16 words and returns its inverse by
// cofactors and adjugate, each entry (cofactor << 16) / det truncated
// toward zero and saturated, with singular and saturated flags.
// Throughput is one matrix per clock while the skid register is empty;
// the pipeline depth is set by the 32 one-bit-per-stage divider stages
// in each of the nine lanes plus the product, cofactor and determinant stages.
// The whole pipeline advances together; a one-word skid register at the
// output lets the pipeline take one more word after rsp_ready drops.
`timescale 1ns / 1ps

module matrix3x3_inverse_unit
   import mi3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  mi3_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output mi3_rsp_type rsp_data
);

   logic                      adv;
   logic [NST-1:0]            valid_ff, valid_in;
   logic signed [ENTRY_W-1:0] m [NLANE];
   logic signed [ENTRY_W-1:0] row0 [3];
   logic signed [COF_W-1:0]   cof [NLANE];
   logic signed [COF_W-1:0]   cof0 [3];
   logic signed [COF_W-1:0]   cofd_ff [NLANE][3];
   logic signed [DET_W-1:0]   det;
   logic                      sing_ff [ST_ABS:ST_OUT-1];
   logic signed [ENTRY_W-1:0] res [NLANE];
   logic                      sat [NLANE];
   mi3_rsp_type               out_ff, out_in;
   mi3_rsp_type               skid_ff;
   logic                      skid_full_ff, skid_full_in;

   // unpack the input word row-major
   assign m[0] = req_data.a_r0c0;
   assign m[1] = req_data.a_r0c1;
   assign m[2] = req_data.a_r0c2;
   assign m[3] = req_data.a_r1c0;
   assign m[4] = req_data.a_r1c1;
   assign m[5] = req_data.a_r1c2;
   assign m[6] = req_data.a_r2c0;
   assign m[7] = req_data.a_r2c1;
   assign m[8] = req_data.a_r2c2;

   // nine cofactor lanes, cyclic rule
   for (genvar r = 0; r < 3; r++) begin : g_cr
      for (genvar c = 0; c < 3; c++) begin : g_cc
         localparam int R1 = (r + 1) % 3;
         localparam int R2 = (r + 2) % 3;
         localparam int C1 = (c + 1) % 3;
         localparam int C2 = (c + 2) % 3;
         mi3_cof_lane u_cof (
            .clock (clock),
            .adv   (adv),
            .a     (m[R1*3+C1]),
            .b     (m[R2*3+C2]),
            .c     (m[R1*3+C2]),
            .d     (m[R2*3+C1]),
            .cof   (cof[r*3+c])
         );
      end
   end

   // determinant from the first row
   assign row0 = '{m[0], m[1], m[2]};
   assign cof0 = '{cof[0], cof[1], cof[2]};

   mi3_det u_det (
      .clock (clock),
      .adv   (adv),
      .row0  (row0),
      .cof0  (cof0),
      .det   (det)
   );

   // hold cofactors until the determinant is ready
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NLANE; l++) begin
            cofd_ff[l][0] <= cof[l];
            cofd_ff[l][1] <= cofd_ff[l][0];
            cofd_ff[l][2] <= cofd_ff[l][1];
         end
      end
   end

   // nine divider lanes; entry (r,c) divides cofactor (c,r)
   for (genvar r = 0; r < 3; r++) begin : g_dr
      for (genvar c = 0; c < 3; c++) begin : g_dc
         mi3_div_lane u_div (
            .clock (clock),
            .adv   (adv),
            .cof   (cofd_ff[c*3+r][2]),
            .det   (det),
            .res   (res[r*3+c]),
            .sat   (sat[r*3+c])
         );
      end
   end

   // carry the singular flag alongside the divider
   always_ff @(posedge clock) begin
      if (adv) begin
         sing_ff[ST_ABS] <= (det == '0);
         for (int s = ST_ABS + 1; s < ST_OUT; s++) begin
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   // merge the lanes into the result word
   always_comb begin
      out_in = '0;
      if (sing_ff[ST_OUT-1]) begin
         out_in.singular = 1'b1;
      end else begin
         out_in.inv_r0c0  = res[0];
         out_in.inv_r0c1  = res[1];
         out_in.inv_r0c2  = res[2];
         out_in.inv_r1c0  = res[3];
         out_in.inv_r1c1  = res[4];
         out_in.inv_r1c2  = res[5];
         out_in.inv_r2c0  = res[6];
         out_in.inv_r2c1  = res[7];
         out_in.inv_r2c2  = res[8];
         out_in.saturated = sat[0] | sat[1] | sat[2] | sat[3] | sat[4]
                          | sat[5] | sat[6] | sat[7] | sat[8];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   // pipeline advances whenever the skid register is empty
   assign adv       = ~skid_full_ff;
   assign req_ready = adv;
   assign valid_in  = {valid_ff[NST-2:0], req_valid};

   // capture the output word if it is not taken while the pipeline moves
   always_comb begin
      skid_full_in = skid_full_ff;
      if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_in = 1'b0;
         end
      end else if (valid_ff[ST_OUT] && !rsp_ready) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_ff <= out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
         if (adv) begin
            valid_ff <= valid_in;
         end
      end
   end

   assign rsp_valid = skid_full_ff | valid_ff[ST_OUT];
   assign rsp_data  = skid_full_ff ? skid_ff : out_ff;

endmodule

/* hw/rtl/mi3_checker.sv */
// Port-level checks for the 3x3 matrix inverse unit, bound to the top level
`timescale 1ns / 1ps

module mi3_checker
   import mi3_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input mi3_rsp_type rsp_data
);

   // a singular word carries zero entries and no clip flag
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         !rsp_data.saturated && rsp_data.inv_r0c0 == '0 && rsp_data.inv_r1c1 == '0
         && rsp_data.inv_r2c2 == '0 && rsp_data.inv_r0c2 == '0 && rsp_data.inv_r2c0 == '0)
      else $error("singular word with non-zero content");

   // nothing waiting at the output means the input side must be open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no word pending");

   // no word straight after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("word shown after reset");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled word changed");

endmodule

bind matrix3x3_inverse_unit mi3_checker u_mi3_checker (.*);
